>>> hdl/i2cmbe_pkg.sv
// shared types and constants for the i2c master bit engine
package i2cmbe_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_CNT_W     = 4;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_ACK   = 3'd5
    } op_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] write_data;
        logic       ack_level;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_seen;
    } result_t;

endpackage

>>> hdl/i2c_master_bit_engine_unit.sv
// top level of the i2c master bit engine: input and result registers around the sequencer
//
// Each accepted item is one tick of the bus timebase and yields exactly one result item
// with the scl/sda line states for that tick, busy and done flags, the last read byte and
// the last write's ack sample. One item is taken per clock cycle while m_ready keeps up;
// items pass the input register and then the result register, and the sequencer step
// between them is a single pass that updates the line state once per item. A stalled
// result holds in the output register while the input register can still take an item.
module i2c_master_bit_engine_unit import i2cmbe_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_opcode,
    input  logic [7:0] s_write_data,
    input  logic       s_ack_level,
    input  logic       s_sda_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl_level,
    output logic       m_sda_level,
    output logic       m_busy_res,
    output logic       m_done_res,
    output logic [7:0] m_read_data,
    output logic       m_ack_seen
);

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    result_t step_res;
    logic    advance, fire, take;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign take    = s_valid && s_ready;

    assign in_valid_next  = take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    i2cmbe_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (fire),
        .item    (in_item_reg),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_item_reg.opcode     <= s_opcode;
            in_item_reg.write_data <= s_write_data;
            in_item_reg.ack_level  <= s_ack_level;
            in_item_reg.sda_in     <= s_sda_in;
        end
        if (fire) begin
            out_res_reg <= step_res;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_scl_level = out_res_reg.scl_level;
    assign m_sda_level = out_res_reg.sda_level;
    assign m_busy_res  = out_res_reg.busy_res;
    assign m_done_res  = out_res_reg.done_res;
    assign m_read_data = out_res_reg.read_data;
    assign m_ack_seen  = out_res_reg.ack_seen;

endmodule

>>> hdl/i2cmbe_seq.sv
// line sequencer state and per-tick step logic
module i2cmbe_seq import i2cmbe_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  item_t   item,
    output result_t res
);

    op_t                  cmd_reg,   cmd_next;
    logic [1:0]           phase_reg, phase_next;
    logic [BIT_CNT_W-1:0] bcnt_reg,  bcnt_next;
    logic [7:0]           shift_reg, shift_next;
    logic                 scl_reg,   scl_next;
    logic                 sda_reg,   sda_next;
    logic                 ack_reg,   ack_next;
    logic [7:0]           rd_reg,    rd_next;
    logic                 o_scl, o_sda, done;
    op_t                  op_in;
    logic                 op_valid;

    assign op_in    = op_t'(item.opcode);
    assign op_valid = (item.opcode >= 3'(OP_START)) && (item.opcode <= 3'(OP_ACK));

    always_comb begin
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        bcnt_next  = bcnt_reg;
        shift_next = shift_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        rd_next    = rd_reg;
        done       = 1'b0;

        // new command only when idle
        if (cmd_reg == OP_NONE && op_valid) begin
            cmd_next   = op_in;
            phase_next = 2'd0;
            bcnt_next  = '0;
            if (op_in == OP_WRITE) begin
                shift_next = item.write_data;
            end else if (op_in == OP_READ) begin
                shift_next = 8'h00;
            end
        end

        o_scl = scl_next;
        o_sda = sda_next;

        unique case (cmd_next)
            OP_START: begin
                if (phase_next == 2'd0) begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end else if (phase_next == 2'd1) begin
                    sda_next = 1'b0;
                end else begin
                    scl_next = 1'b0;
                    done     = 1'b1;
                end
                o_scl      = scl_next;
                o_sda      = sda_next;
                phase_next = 2'(phase_next + 2'd1);
            end
            OP_STOP: begin
                if (phase_next == 2'd0) begin
                    sda_next = 1'b0;
                end else if (phase_next == 2'd1) begin
                    scl_next = 1'b1;
                end else begin
                    sda_next = 1'b1;
                    done     = 1'b1;
                end
                o_scl      = scl_next;
                o_sda      = sda_next;
                phase_next = 2'(phase_next + 2'd1);
            end
            OP_ACK: begin
                if (phase_next == 2'd0) begin
                    sda_next = item.ack_level;
                end else if (phase_next == 2'd1) begin
                    scl_next = 1'b1;
                end else begin
                    scl_next = 1'b0;
                    done     = 1'b1;
                end
                o_scl      = scl_next;
                o_sda      = sda_next;
                phase_next = 2'(phase_next + 2'd1);
            end
            OP_WRITE: begin
                if (bcnt_next < BIT_CNT_W'(BITS_PER_BYTE)) begin
                    if (phase_next == 2'd0) begin
                        sda_next   = shift_next[7];
                        o_scl      = scl_next;
                        o_sda      = sda_next;
                        phase_next = 2'd1;
                    end else begin
                        o_scl      = 1'b1;
                        o_sda      = sda_next;
                        scl_next   = 1'b0;
                        shift_next = {shift_next[6:0], 1'b0};
                        bcnt_next  = BIT_CNT_W'(bcnt_next + 1'b1);
                        phase_next = 2'd0;
                    end
                end else begin
                    if (phase_next == 2'd0) begin
                        sda_next   = 1'b1;
                        o_scl      = scl_next;
                        o_sda      = sda_next;
                        phase_next = 2'd1;
                    end else begin
                        // ack slot, sample while scl is high
                        o_scl    = 1'b1;
                        o_sda    = sda_next;
                        ack_next = item.sda_in;
                        scl_next = 1'b0;
                        done     = 1'b1;
                    end
                end
            end
            OP_READ: begin
                if (phase_next == 2'd0) begin
                    sda_next   = 1'b1;
                    phase_next = 2'd1;
                end else if (phase_next == 2'd1) begin
                    scl_next   = 1'b1;
                    shift_next = {shift_next[6:0], item.sda_in};
                    phase_next = 2'd2;
                end else begin
                    scl_next   = 1'b0;
                    phase_next = 2'd0;
                    bcnt_next  = BIT_CNT_W'(bcnt_next + 1'b1);
                    if (bcnt_next >= BIT_CNT_W'(BITS_PER_BYTE)) begin
                        rd_next = shift_next;
                        done    = 1'b1;
                    end
                end
                o_scl = scl_next;
                o_sda = sda_next;
            end
            default: begin
            end
        endcase

        if (done) begin
            cmd_next   = OP_NONE;
            phase_next = 2'd0;
            bcnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg   <= OP_NONE;
            phase_reg <= 2'd0;
            bcnt_reg  <= '0;
            shift_reg <= 8'h00;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ack_reg   <= 1'b1;
            rd_reg    <= 8'h00;
        end else if (step_en) begin
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            bcnt_reg  <= bcnt_next;
            shift_reg <= shift_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
            rd_reg    <= rd_next;
        end
    end

    always_comb begin
        res.scl_level = o_scl;
        res.sda_level = o_sda;
        res.busy_res  = (cmd_next != OP_NONE);
        res.done_res  = done;
        res.read_data = rd_next;
        res.ack_seen  = ack_next;
    end

endmodule

>>> verif/testbench.sv
// self-checking testbench for the i2c master bit engine with a cycle-level line sequencer model
`timescale 1ns / 100ps

module testbench;
    import i2cmbe_pkg::*;

    localparam int TOTAL_ITEMS    = 1150;
    localparam int STALL_MAX      = 17;
    localparam int LONG_HOLD      = 120;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SDA_RANDOM     = -1;

    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [2:0] s_opcode;
    logic [7:0] s_write_data;
    logic       s_ack_level;
    logic       s_sda_in;
    logic       m_valid;
    logic       m_ready;
    logic       m_scl_level;
    logic       m_sda_level;
    logic       m_busy_res;
    logic       m_done_res;
    logic [7:0] m_read_data;
    logic       m_ack_seen;

    // line sequencer model state
    op_t        cur_cmd;
    logic [1:0] step_phase;
    logic [3:0] bits_done;
    logic [7:0] shreg;
    logic       scl_q;
    logic       sda_q;
    logic       ack_q;
    logic [7:0] rd_byte;

    result_t     expected_ticks[$];
    int unsigned sent_items;
    int unsigned seen_ticks;
    int unsigned err_count;
    bit          tx_idle_en;
    bit          rx_idle_en;
    int          rx_hold_req;

    i2c_master_bit_engine_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_write_data (s_write_data),
        .s_ack_level  (s_ack_level),
        .s_sda_in     (s_sda_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_scl_level  (m_scl_level),
        .m_sda_level  (m_sda_level),
        .m_busy_res   (m_busy_res),
        .m_done_res   (m_done_res),
        .m_read_data  (m_read_data),
        .m_ack_seen   (m_ack_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function void bus_reset();
        cur_cmd    = OP_NONE;
        step_phase = '0;
        bits_done  = '0;
        shreg      = '0;
        scl_q      = 1'b1;
        sda_q      = 1'b1;
        ack_q      = 1'b1;
        rd_byte    = '0;
    endfunction

    // one bus tick: returns the line states and flags for this item
    function result_t bus_tick(item_t it);
        result_t r;
        logic    done;
        done = 1'b0;
        if (cur_cmd == OP_NONE && it.opcode >= OP_START && it.opcode <= OP_ACK) begin
            cur_cmd    = op_t'(it.opcode);
            step_phase = '0;
            bits_done  = '0;
            if (it.opcode == OP_WRITE) begin
                shreg = it.write_data;
            end else if (it.opcode == OP_READ) begin
                shreg = '0;
            end
        end
        r.scl_level = scl_q;
        r.sda_level = sda_q;
        case (cur_cmd)
            OP_START: begin
                if (step_phase == 0) begin
                    scl_q = 1'b1;
                    sda_q = 1'b1;
                end else if (step_phase == 1) begin
                    sda_q = 1'b0;
                end else begin
                    scl_q = 1'b0;
                    done  = 1'b1;
                end
                r.scl_level = scl_q;
                r.sda_level = sda_q;
                step_phase  = step_phase + 2'd1;
            end
            OP_STOP: begin
                if (step_phase == 0) begin
                    sda_q = 1'b0;
                end else if (step_phase == 1) begin
                    scl_q = 1'b1;
                end else begin
                    sda_q = 1'b1;
                    done  = 1'b1;
                end
                r.scl_level = scl_q;
                r.sda_level = sda_q;
                step_phase  = step_phase + 2'd1;
            end
            OP_ACK: begin
                if (step_phase == 0) begin
                    sda_q = it.ack_level;
                end else if (step_phase == 1) begin
                    scl_q = 1'b1;
                end else begin
                    scl_q = 1'b0;
                    done  = 1'b1;
                end
                r.scl_level = scl_q;
                r.sda_level = sda_q;
                step_phase  = step_phase + 2'd1;
            end
            OP_WRITE: begin
                if (bits_done < BITS_PER_BYTE) begin
                    if (step_phase == 0) begin
                        sda_q       = shreg[7];
                        r.scl_level = scl_q;
                        r.sda_level = sda_q;
                        step_phase  = 2'd1;
                    end else begin
                        r.scl_level = 1'b1;
                        r.sda_level = sda_q;
                        scl_q       = 1'b0;
                        shreg       = shreg << 1;
                        bits_done   = bits_done + 4'd1;
                        step_phase  = 2'd0;
                    end
                end else begin
                    if (step_phase == 0) begin
                        sda_q       = 1'b1;
                        r.scl_level = scl_q;
                        r.sda_level = sda_q;
                        step_phase  = 2'd1;
                    end else begin
                        r.scl_level = 1'b1;
                        r.sda_level = sda_q;
                        ack_q       = it.sda_in;
                        scl_q       = 1'b0;
                        done        = 1'b1;
                    end
                end
            end
            OP_READ: begin
                if (step_phase == 0) begin
                    sda_q      = 1'b1;
                    step_phase = 2'd1;
                end else if (step_phase == 1) begin
                    scl_q      = 1'b1;
                    shreg      = {shreg[6:0], it.sda_in};
                    step_phase = 2'd2;
                end else begin
                    scl_q      = 1'b0;
                    step_phase = 2'd0;
                    bits_done  = bits_done + 4'd1;
                    if (bits_done >= BITS_PER_BYTE) begin
                        rd_byte = shreg;
                        done    = 1'b1;
                    end
                end
                r.scl_level = scl_q;
                r.sda_level = sda_q;
            end
            default: ;
        endcase
        if (done) begin
            cur_cmd    = OP_NONE;
            step_phase = '0;
            bits_done  = '0;
        end
        r.busy_res  = (cur_cmd != OP_NONE);
        r.done_res  = done;
        r.read_data = rd_byte;
        r.ack_seen  = ack_q;
        return r;
    endfunction

    task automatic log_mismatch(string field, logic [7:0] got, logic [7:0] want);
        $display("result %0d: %s got %0h expected %0h", seen_ticks, field, got, want);
        err_count++;
    endtask

    task automatic check_tick(result_t got);
        result_t want;
        if (expected_ticks.size() == 0) begin
            log_mismatch("m_valid with nothing pending", 8'd1, 8'd0);
        end else begin
            want = expected_ticks.pop_front();
            if (got.scl_level !== want.scl_level)
                log_mismatch("scl_level", 8'(got.scl_level), 8'(want.scl_level));
            if (got.sda_level !== want.sda_level)
                log_mismatch("sda_level", 8'(got.sda_level), 8'(want.sda_level));
            if (got.busy_res !== want.busy_res)
                log_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
            if (got.done_res !== want.done_res)
                log_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
            if (got.read_data !== want.read_data)
                log_mismatch("read_data", got.read_data, want.read_data);
            if (got.ack_seen !== want.ack_seen)
                log_mismatch("ack_seen", 8'(got.ack_seen), 8'(want.ack_seen));
        end
        seen_ticks++;
    endtask

    task automatic send_item(item_t it);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, STALL_MAX) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_opcode     <= it.opcode;
        s_write_data <= it.write_data;
        s_ack_level  <= it.ack_level;
        s_sda_in     <= it.sda_in;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_ticks.push_back(bus_tick(it));
        sent_items++;
    endtask

    // sda for the next tick, either random or taken msb first from a pattern byte
    function logic pick_sda(int pat);
        int idx;
        idx = (bits_done < BITS_PER_BYTE) ? 7 - bits_done : 0;
        if (pat < 0) return 1'($urandom_range(0, 1));
        return pat[idx];
    endfunction

    // issue one command tick, then keep ticking with junk commands until idle again
    task automatic run_command(logic [2:0] op, logic [7:0] data, logic ack, int sda_pat);
        item_t it;
        it.opcode     = op;
        it.write_data = data;
        it.ack_level  = ack;
        it.sda_in     = pick_sda(sda_pat);
        send_item(it);
        while (cur_cmd != OP_NONE) begin
            it.opcode     = 3'($urandom_range(0, 7));
            it.write_data = 8'($urandom_range(0, 255));
            it.ack_level  = 1'($urandom_range(0, 1));
            it.sda_in     = pick_sda(sda_pat);
            send_item(it);
        end
    endtask

    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge aclk);
    endtask

    task automatic test_line_framing();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_command(OP_NONE, 8'h00, 1'b0, SDA_RANDOM);
        run_command(OP_UNUSED_6, 8'hFF, 1'b1, SDA_RANDOM);
        run_command(OP_UNUSED_7, 8'h00, 1'b0, SDA_RANDOM);
        run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM);
        run_command(OP_ACK, 8'h00, 1'b0, SDA_RANDOM);
        run_command(OP_ACK, 8'hFF, 1'b1, SDA_RANDOM);
        run_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM);
    endtask

    task automatic test_byte_transfers();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM);
        run_command(OP_WRITE, 8'hFF, 1'b1, 8'h00);
        run_command(OP_WRITE, 8'h00, 1'b0, 8'hFF);
        run_command(OP_READ, 8'hFF, 1'b0, 8'h96);
        run_command(OP_ACK, 8'h00, 1'b1, SDA_RANDOM);
        run_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM);
    endtask

    task automatic test_backpressure();
        tx_idle_en  = 1'b0;
        rx_idle_en  = 1'b0;
        rx_hold_req = LONG_HOLD;
        run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM);
        run_command(OP_WRITE, 8'($urandom_range(0, 255)), 1'b0, SDA_RANDOM);
        run_command(OP_READ, 8'h00, 1'b0, SDA_RANDOM);
        run_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM);
    endtask

    task automatic test_drain_pause();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM);
        run_command(OP_READ, 8'h00, 1'b0, SDA_RANDOM);
        wait_results_drained();
        run_command(OP_ACK, 8'h00, 1'b1, SDA_RANDOM);
        run_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM);
    endtask

    task automatic test_random_transactions();
        int nbytes;
        while (sent_items < TOTAL_ITEMS) begin
            if ($urandom_range(0, 3) == 0) tx_idle_en = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 3) == 0) rx_idle_en = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 7) == 0) begin
                // out-of-order commands and idle codes
                repeat ($urandom_range(1, 4)) begin
                    run_command(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)), SDA_RANDOM);
                end
            end else begin
                run_command(OP_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            SDA_RANDOM);
                nbytes = $urandom_range(1, 4);
                for (int b = 0; b < nbytes; b++) begin
                    if ($urandom_range(0, 1) == 1) begin
                        run_command(OP_WRITE, 8'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1)), SDA_RANDOM);
                    end else begin
                        run_command(OP_READ, 8'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1)), SDA_RANDOM);
                        run_command(OP_ACK, 8'($urandom_range(0, 255)),
                                    (b == nbytes - 1) ? 1'b1 : 1'($urandom_range(0, 1)),
                                    SDA_RANDOM);
                    end
                    if ($urandom_range(0, 5) == 0)
                        run_command(OP_NONE, 8'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1)), SDA_RANDOM);
                end
                run_command(OP_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            SDA_RANDOM);
            end
        end
    endtask

    // result side: random stalls plus the long hold requested by a test
    initial begin
        int      rx_wait;
        result_t got;
        rx_wait = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got.scl_level = m_scl_level;
                got.sda_level = m_sda_level;
                got.busy_res  = m_busy_res;
                got.done_res  = m_done_res;
                got.read_data = m_read_data;
                got.ack_seen  = m_ack_seen;
                check_tick(got);
                rx_wait = rx_idle_en ? $urandom_range(0, STALL_MAX) : 0;
            end
            @(negedge aclk);
            if (rx_hold_req > 0) begin
                rx_wait     = rx_hold_req;
                rx_hold_req = 0;
            end
            m_ready <= (rx_wait == 0);
            if (rx_wait > 0) rx_wait--;
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_opcode     = OP_NONE;
        s_write_data = '0;
        s_ack_level  = 1'b0;
        s_sda_in     = 1'b0;
        tx_idle_en   = 1'b0;
        rx_idle_en   = 1'b0;
        rx_hold_req  = 0;
        sent_items   = 0;
        seen_ticks   = 0;
        err_count    = 0;
        bus_reset();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_line_framing();
        test_byte_transfers();
        test_backpressure();
        test_drain_pause();
        test_random_transactions();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/i2cmbe_pkg.sv
hdl/i2cmbe_seq.sv
hdl/i2c_master_bit_engine_unit.sv
verif/testbench.sv
